// ----- rtl/core/puptrk_pkg.sv -----
`default_nettype none
package puptrk_pkg;

   localparam int unsigned LIMIT_RESET = 1200;

   typedef enum logic [1:0] {
      MODE_CONF = 2'd0,
      MODE_EDIT = 2'd1,
      MODE_NONE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      CSR_MODE  = 2'd0,
      CSR_LIMIT = 2'd1,
      CSR_EDIT  = 2'd2
   } csr_idx_type;

   typedef enum logic [2:0] {
      KIND_REP     = 3'd0,
      KIND_CHAIR   = 3'd1,
      KIND_ONLINE  = 3'd2,
      KIND_CONFIRM = 3'd3,
      KIND_OTHER   = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      CODE_QUERY   = 3'd0,
      CODE_OFFLINE = 3'd1,
      CODE_DUP     = 3'd2,
      CODE_GRANT   = 3'd3,
      CODE_EDIT    = 3'd4,
      CODE_CONFIRM = 3'd5,
      CODE_FORWARD = 3'd6
   } code_type;

   typedef enum logic [1:0] {
      CMD_POLL = 2'd0,
      CMD_EDIT = 2'd1,
      CMD_MSG  = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type cmd;
      logic [5:0]   id;
      logic [2:0]   kind;
      logic [47:0]  mac;
      logic [31:0]  payload;
      logic [5:0]   edit_id;
   } cmd_type;

   typedef struct packed {
      logic        to_conference;
      logic [5:0]  dest_id;
      logic        broadcast;
      logic [2:0]  msg_code;
      logic [5:0]  edit_id;
      logic        has_mac;
      logic [47:0] mac;
      logic [31:0] fwd_payload;
      logic        last;
   } rsp_type;

endpackage
`default_nettype wire

// ----- rtl/core/puptrk_front.sv -----
`default_nettype none
module puptrk_front
   import puptrk_pkg::*;
#(
   parameter int unsigned MAX_UNITS = 31
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [98:0]   req_tdata,
   input  wire logic          req_tuser,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [1:0]    csr_index,
   input  wire logic [11:0]   csr_wdata,
   output logic [1:0]         mode,
   output logic [11:0]        miss_limit,
   output logic               cmd_valid,
   input  wire logic          cmd_ready,
   output cmd_type            cmd
);
   logic [1:0]  mode_ff;
   logic [11:0] limit_ff;
   logic [5:0]  edit_ff;
   cmd_type     cmd_ff, cmd_in;
   logic        valid_ff, keep;
   logic [15:0] uid;
   logic [2:0]  kind;

   assign csr_ready  = 1'b1;
   assign mode       = mode_ff;
   assign miss_limit = limit_ff;
   assign req_tready = !valid_ff || cmd_ready;
   assign cmd_valid  = valid_ff;
   assign cmd        = cmd_ff;
   assign uid        = req_tdata[15:0];
   assign kind       = (req_tdata[18:16] > KIND_OTHER) ? KIND_OTHER : req_tdata[18:16];

   always_comb begin
      cmd_in         = '0;
      cmd_in.id      = uid[5:0];
      cmd_in.kind    = kind;
      cmd_in.mac     = req_tdata[66:19];
      cmd_in.payload = req_tdata[98:67];
      cmd_in.edit_id = edit_ff;
      keep           = 1'b0;
      if (req_tuser) begin
         cmd_in.cmd = CMD_MSG;
         keep = (uid >= 16'd1) && (uid <= 16'(MAX_UNITS));
      end else if (mode_ff == MODE_CONF) begin
         cmd_in.cmd = CMD_POLL;
         keep = 1'b1;
      end else if (mode_ff == MODE_EDIT) begin
         cmd_in.cmd = CMD_EDIT;
         keep = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_CONF;
         limit_ff <= 12'(LIMIT_RESET);
         edit_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_MODE:  mode_ff  <= csr_wdata[1:0];
               CSR_LIMIT: limit_ff <= csr_wdata;
               CSR_EDIT:  edit_ff  <= csr_wdata[5:0];
               default:   ;
            endcase
         end
         if (req_tready) begin
            valid_ff <= req_tvalid && keep;
            cmd_ff   <= cmd_in;
         end
      end
   end
endmodule
`default_nettype wire

// ----- rtl/core/puptrk_back.sv -----
`default_nettype none
module puptrk_back
   import puptrk_pkg::*;
#(
   parameter int unsigned MAX_UNITS = 31
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [11:0]   miss_limit,
   input  wire logic          cmd_valid,
   output logic               cmd_ready,
   input  wire cmd_type       cmd,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output rsp_type            rsp
);
   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_SECOND} state_type;

   logic [MAX_UNITS-1:0] online_ff;
   logic [11:0]          miss_ff [MAX_UNITS];
   logic [47:0]          mac_ff  [MAX_UNITS];
   logic                 role_ff [MAX_UNITS];
   state_type            state_ff;
   logic [5:0]           id_ff;
   rsp_type              rsp_ff, second_ff;
   logic                 rvalid_ff;
   logic                 free;
   logic [4:0]           slot;
   logic [5:0]           next_id;
   logic                 rsp_load;

   assign free      = !rvalid_ff || rsp_ready;
   assign rsp_valid = rvalid_ff;
   assign rsp       = rsp_ff;
   assign cmd_ready = (state_ff == ST_IDLE) && free;
   assign slot      = 5'(cmd.id - 6'd1);
   assign next_id   = id_ff + 6'd1;

   // any online unit above the given id
   function automatic logic later_after(logic [5:0] id);
      logic r;
      r = 1'b0;
      for (int i = 0; i < MAX_UNITS; i++) begin
         if (6'(i + 1) > id && online_ff[i]) r = 1'b1;
      end
      return r;
   endfunction

   function automatic rsp_type mk(logic conf, logic [5:0] id, logic bc, code_type code,
                                  logic [5:0] eid, logic hm, logic [47:0] mac,
                                  logic [31:0] pay, logic last);
      rsp_type r;
      r = '0;
      r.to_conference = conf;
      r.dest_id = id;
      r.broadcast = bc;
      r.msg_code = code;
      r.edit_id = eid;
      r.has_mac = hm;
      r.mac = mac;
      r.fwd_payload = pay;
      r.last = last;
      return r;
   endfunction

   always_comb begin
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE:
            rsp_load = cmd_valid && free &&
                       (cmd.cmd == CMD_EDIT ||
                        (cmd.cmd == CMD_MSG &&
                         !(online_ff[slot] && cmd.kind == KIND_ONLINE)));
         ST_SCAN:
            rsp_load = free && (id_ff != 6'(MAX_UNITS)) && online_ff[5'(id_ff)];
         ST_SECOND:
            rsp_load = free;
         default:
            rsp_load = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rvalid_ff <= 1'b0;
         online_ff <= '0;
         for (int i = 0; i < MAX_UNITS; i++) miss_ff[i] <= '0;
      end else begin
         rvalid_ff <= rsp_load || (rvalid_ff && !rsp_ready);
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_valid && free) begin
                  unique case (cmd.cmd)
                     CMD_POLL: begin
                        id_ff    <= '0;
                        state_ff <= ST_SCAN;
                     end
                     CMD_EDIT: begin
                        rsp_ff <= mk(1'b0, 6'd0, 1'b1, CODE_EDIT, cmd.edit_id, 1'b0,
                                     '0, '0, 1'b1);
                     end
                     CMD_MSG: begin
                        if (online_ff[slot] || cmd.kind == KIND_REP ||
                            cmd.kind == KIND_CHAIR)
                           miss_ff[slot] <= '0;
                        if (cmd.kind == KIND_REP || cmd.kind == KIND_CHAIR) begin
                           if (online_ff[slot] && mac_ff[slot] != cmd.mac) begin
                              rsp_ff    <= mk(1'b0, cmd.id, 1'b0, CODE_DUP, '0, 1'b0,
                                              '0, '0, 1'b0);
                              second_ff <= mk(1'b1, cmd.id, 1'b0, CODE_DUP, '0, 1'b0,
                                              '0, '0, 1'b1);
                              state_ff  <= ST_SECOND;
                           end else begin
                              role_ff[slot] <= cmd.kind[0];
                              mac_ff[slot]  <= cmd.mac;
                              rsp_ff <= mk(1'b0, cmd.id, 1'b0, CODE_GRANT, '0, 1'b0,
                                           '0, '0, online_ff[slot]);
                              if (!online_ff[slot]) begin
                                 online_ff[slot] <= 1'b1;
                                 second_ff <= mk(1'b1, cmd.id, 1'b0, CODE_GRANT, '0,
                                                 1'b0, '0, '0, 1'b1);
                                 state_ff <= ST_SECOND;
                              end
                           end
                        end else if (online_ff[slot]) begin
                           if (cmd.kind != KIND_ONLINE) begin
                              rsp_ff <= mk(1'b1, cmd.id, 1'b0, CODE_FORWARD, '0, 1'b0,
                                           '0, cmd.payload, 1'b1);
                           end
                        end else if (cmd.kind == KIND_CONFIRM) begin
                           rsp_ff <= mk(1'b1, cmd.id, 1'b0, CODE_CONFIRM, '0, 1'b1,
                                        cmd.mac, '0, 1'b1);
                        end else begin
                           rsp_ff <= mk(1'b0, cmd.id, 1'b0, CODE_OFFLINE, '0, 1'b0,
                                        '0, '0, 1'b1);
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_SCAN: begin
               // id_ff is the last unit handled; advance to the next one
               if (free) begin
                  if (id_ff == 6'(MAX_UNITS)) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     id_ff <= next_id;
                     if (online_ff[5'(id_ff)]) begin
                        if (miss_ff[5'(id_ff)] < miss_limit) begin
                           miss_ff[5'(id_ff)] <= miss_ff[5'(id_ff)] + 12'd1;
                           rsp_ff <= mk(1'b0, next_id, 1'b0, CODE_QUERY, '0, 1'b0,
                                        '0, '0, !later_after(next_id));
                        end else begin
                           online_ff[5'(id_ff)] <= 1'b0;
                           rsp_ff <= mk(1'b1, next_id, 1'b0, CODE_OFFLINE, '0, 1'b0,
                                        '0, '0, 1'b0);
                           second_ff <= mk(1'b0, next_id, 1'b0, CODE_OFFLINE, '0, 1'b0,
                                           '0, '0, !later_after(next_id));
                           state_ff <= ST_SECOND;
                        end
                     end
                  end
               end
            end
            ST_SECOND: begin
               if (free) begin
                  rsp_ff <= second_ff;
                  if (!second_ff.last)
                     state_ff <= ST_SCAN;
                  else
                     state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   logic unused_role;
   assign unused_role = role_ff[0];
endmodule
`default_nettype wire

// ----- rtl/core/polled_unit_presence_tracker_core.sv -----
`default_nettype none
// Presence table for up to MAX_UNITS polled units (ids 1..MAX_UNITS).
// req_tuser selects the item: 0 poll tick, 1 received message. A message
// gives at most two results. A conference poll tick walks the table one
// unit id per cycle while results are taken, and a unit that goes offline
// gives two results. Results stall the walk while rsp_tready is low; a
// short command register between the input side and the table lets the
// next item be taken meanwhile. The last result of each item has rsp_tlast
// set; items that cause no result show nothing.
module polled_unit_presence_tracker_core
   import puptrk_pkg::*;
#(
   parameter int unsigned MAX_UNITS = 31
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [103:0]  req_tdata,  // unit_id, msg_kind, src_mac, payload
   input  wire logic          req_tuser,  // opcode
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [95:0]        rsp_tdata,  // dest_id, msg_code, edit_id, mac, fwd_payload
   output logic [2:0]         rsp_tuser,  // to_conference, broadcast, has_mac
   output logic               rsp_tlast,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [1:0]    csr_index,
   input  wire logic [11:0]   csr_wdata
);
   logic [1:0]  mode;
   logic [11:0] miss_limit;
   logic        cmd_valid, cmd_ready;
   cmd_type     cmd;
   rsp_type     rsp;

   puptrk_front #(.MAX_UNITS(MAX_UNITS)) u_front (
      .clock, .reset, .req_tvalid, .req_tready,
      .req_tdata(req_tdata[98:0]), .req_tuser,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .mode, .miss_limit, .cmd_valid, .cmd_ready, .cmd
   );

   puptrk_back #(.MAX_UNITS(MAX_UNITS)) u_back (
      .clock, .reset, .miss_limit, .cmd_valid, .cmd_ready, .cmd,
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp
   );

   logic unused_in;
   assign unused_in = ^{req_tdata[103:99], mode};

   assign rsp_tdata = {1'b0, rsp.fwd_payload, rsp.mac, rsp.edit_id, rsp.msg_code, rsp.dest_id};
   assign rsp_tuser = {rsp.has_mac, rsp.broadcast, rsp.to_conference};
   assign rsp_tlast = rsp.last;
endmodule
`default_nettype wire
